// ===== hw/rtl/rbnh_pkg.sv =====
// ---------------------------------------------------------------------------
// rbnh_pkg: shared types and constants for the ray/box nearest hit block
// Widths, payload structs, register codes and sequencer states.
// ---------------------------------------------------------------------------
package rbnh_pkg;

  localparam int MAX_BOXES  = 1024;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int COORD_W    = 32;
  localparam int DIR_W      = 18;
  localparam int DIST_W     = 31;
  localparam int HIT_IDX_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int NUM_W      = DIFF_W + FRAC_W;
  localparam int QMAG_W     = NUM_W - 1;
  localparam int T_W        = 33;

  localparam logic [DIST_W-1:0]       MAX_DIST_RST = 31'd13107200;
  localparam logic signed [DIR_W-1:0] DIR_X_RST    = 18'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_MAX_DIST = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_lo_x;
    logic signed [COORD_W-1:0] box_lo_y;
    logic signed [COORD_W-1:0] box_lo_z;
    logic signed [COORD_W-1:0] box_hi_x;
    logic signed [COORD_W-1:0] box_hi_y;
    logic signed [COORD_W-1:0] box_hi_z;
    logic                      last_box;
  } box_t;

  typedef struct packed {
    logic                 any_hit;
    logic [DIST_W-1:0]    hit_distance;
    logic [HIT_IDX_W-1:0] hit_box_index;
  } res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic [DIST_W-1:0]         max_distance;
  } ray_t;

endpackage

// ===== hw/rtl/rbnh_div.sv =====
// ---------------------------------------------------------------------------
// rbnh_div: shared serial signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero. done_o pulses for one cycle with quo_o valid.
// ---------------------------------------------------------------------------
module rbnh_div import rbnh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DIR_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QMAG_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q, neg_q;
  logic [QMAG_W-1:0] dvd_q;
  logic [DIR_W-1:0]  den_q, rem_q;
  logic [NUM_W-1:0]  num_abs;
  logic [DIR_W-1:0]  den_abs;
  logic [DIR_W:0]    shifted;
  logic [DIR_W+1:0]  trial;

  assign num_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign den_abs = den_i[DIR_W-1] ? DIR_W'(-den_i) : DIR_W'(den_i);
  assign shifted = {rem_q, dvd_q[QMAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QMAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1] ^ den_i[DIR_W-1];
      dvd_q <= num_abs[QMAG_W-1:0];
      den_q <= den_abs;
      rem_q <= '0;
    end else if (busy_q) begin
      // keep the remainder when the trial subtract goes negative
      rem_q <= trial[DIR_W+1] ? shifted[DIR_W-1:0] : trial[DIR_W-1:0];
      dvd_q <= {dvd_q[QMAG_W-2:0], ~trial[DIR_W+1]};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

// ===== hw/rtl/rbnh_core.sv =====
// ---------------------------------------------------------------------------
// rbnh_core: slab clipping sequencer and query state
// Walks the three axes of one box, feeding entry and exit distances through
// the shared divider, and keeps the running nearest hit of the query.
// ---------------------------------------------------------------------------
module rbnh_core import rbnh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  box_t              in_box_i,
  output logic              in_ready_o,
  input  ray_t              ray_i,
  input  logic              max_wr_i,
  input  logic [DIST_W-1:0] max_val_i,
  input  logic              out_free_i,
  output logic              res_load_o,
  output res_t              res_o
);

  state_e state_q, state_d;
  box_t   box_q;
  axis_e  axis_q;
  logic   hit_q;
  logic signed [T_W-1:0] tmin_q, tmax_q, t0_q;
  logic [DIST_W-1:0] near_q;
  logic [IDX_W-1:0]  near_idx_q, cnt_q;
  logic              found_q;

  logic signed [COORD_W-1:0] org, lo, hi;
  logic signed [DIR_W-1:0]   dir;
  logic signed [DIFF_W-1:0]  diff_lo, diff_hi;
  logic signed [NUM_W-1:0]   div_num, div_quo;
  logic                      div_start, div_done;
  logic                      par_pass, last_axis;
  logic signed [T_W-1:0]     t1, t_near, t_far, ntmin, ntmax;

  function automatic logic signed [T_W-1:0] clamp_t(input logic signed [NUM_W-1:0] q);
    logic signed [T_W-1:0] r;
    // anything past the top of the range rejects the same way as 2^31
    if (q[NUM_W-1]) begin
      r = '1;
    end else if (|q[NUM_W-2:T_W-1]) begin
      r = T_W'(33'h0_8000_0000);
    end else begin
      r = q[T_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        org = ray_i.origin_x; dir = ray_i.dir_x; lo = box_q.box_lo_x; hi = box_q.box_hi_x;
      end
      AXIS_Y: begin
        org = ray_i.origin_y; dir = ray_i.dir_y; lo = box_q.box_lo_y; hi = box_q.box_hi_y;
      end
      default: begin
        org = ray_i.origin_z; dir = ray_i.dir_z; lo = box_q.box_lo_z; hi = box_q.box_hi_z;
      end
    endcase
  end

  assign diff_lo   = DIFF_W'(lo) - DIFF_W'(org);
  assign diff_hi   = DIFF_W'(hi) - DIFF_W'(org);
  assign div_num   = (state_q == ST_AXIS) ? {diff_lo, {FRAC_W{1'b0}}}
                                          : {diff_hi, {FRAC_W{1'b0}}};
  assign par_pass  = !(org < lo || org > hi);
  assign last_axis = (axis_q == AXIS_Z);

  assign t1     = clamp_t(div_quo);
  assign t_near = (t0_q > t1) ? t1 : t0_q;
  assign t_far  = (t0_q > t1) ? t0_q : t1;
  assign ntmin  = (t_near > tmin_q) ? t_near : tmin_q;
  assign ntmax  = (t_far < tmax_q) ? t_far : tmax_q;

  rbnh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dir),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_AXIS;
      ST_AXIS: begin
        if (dir != '0) begin
          state_d = ST_DIV_LO;
        end else if (!par_pass || last_axis) begin
          state_d = ST_COMMIT;
        end
      end
      ST_DIV_LO: if (div_done) state_d = ST_DIV_HI;
      ST_DIV_HI: begin
        if (div_done) begin
          state_d = ((ntmin > ntmax) || last_axis) ? ST_COMMIT : ST_AXIS;
        end
      end
      ST_COMMIT: state_d = box_q.last_box ? ST_FINISH : ST_IDLE;
      ST_FINISH: if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    div_start  = ((state_q == ST_AXIS) && (dir != '0)) ||
                 ((state_q == ST_DIV_LO) && div_done);
    res_load_o = (state_q == ST_FINISH) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      near_q     <= MAX_DIST_RST;
      near_idx_q <= '0;
      cnt_q      <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (max_wr_i && (cnt_q == '0) && !found_q) begin
        near_q <= max_val_i;
      end
      case (state_q)
        ST_COMMIT: begin
          if (hit_q && (tmin_q < $signed({2'b00, near_q}))) begin
            near_q     <= tmin_q[DIST_W-1:0];
            near_idx_q <= cnt_q;
            found_q    <= 1'b1;
          end
          if (cnt_q != IDX_W'(MAX_BOXES - 1)) begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free_i) begin
            near_q     <= ray_i.max_distance;
            near_idx_q <= '0;
            cnt_q      <= '0;
            found_q    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          box_q  <= in_box_i;
          axis_q <= AXIS_X;
          tmin_q <= '0;
          tmax_q <= $signed({2'b00, near_q});
        end
      end
      ST_AXIS: begin
        if (dir == '0) begin
          hit_q  <= par_pass;
          axis_q <= axis_e'(axis_q + 2'd1);
        end
      end
      ST_DIV_LO: if (div_done) t0_q <= clamp_t(div_quo);
      ST_DIV_HI: begin
        if (div_done) begin
          tmin_q <= ntmin;
          tmax_q <= ntmax;
          hit_q  <= !(ntmin > ntmax);
          axis_q <= axis_e'(axis_q + 2'd1);
        end
      end
      default: ;
    endcase
  end

  assign res_o.any_hit       = found_q;
  assign res_o.hit_distance  = near_q;
  assign res_o.hit_box_index = HIT_IDX_W'(near_idx_q);

endmodule

// ===== hw/rtl/ray_box_nearest_hit_top.sv =====
// ---------------------------------------------------------------------------
// ray_box_nearest_hit_top: nearest box hit along a configured ray
// Slab test of streamed boxes against one ray, one result per query.
// ---------------------------------------------------------------------------
//   channel   signals                               word
//   in        in_valid_i / in_ready_o / in_box_i    box_t, one box
//   out       out_valid_o / out_ready_i / out_res_o res_t, one per query
//   cfg       cfg_we_i / cfg_idx_i / cfg_wdata_i    register write, no wait
//
// a box steps through its axes in turn (x, y, z), then commit and idle; a
// parallel axis needs no division, and a dividing axis has a setup step and
// two 48-bit quotients (low plane, then high plane) in the shared serial
// divider. a box stops at the first axis that misses. a last box also passes
// through finish. one box is in flight at a time.
// a result waits in the output register; a last box stalls only while the
// previous result is still held. reset loads the register defaults.
// ---------------------------------------------------------------------------
module ray_box_nearest_hit_top import rbnh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  box_t                  in_box_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_t                  out_res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  ray_t ray_q;
  logic out_valid_q;
  res_t res_q, core_res;
  logic res_load, out_free, max_wr;

  assign out_free = !out_valid_q || out_ready_i;
  assign max_wr   = cfg_we_i && (cfg_idx_i == REG_MAX_DIST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q.origin_x     <= '0;
      ray_q.origin_y     <= '0;
      ray_q.origin_z     <= '0;
      ray_q.dir_x        <= DIR_X_RST;
      ray_q.dir_y        <= '0;
      ray_q.dir_z        <= '0;
      ray_q.max_distance <= MAX_DIST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X: ray_q.origin_x     <= cfg_wdata_i;
        REG_ORIGIN_Y: ray_q.origin_y     <= cfg_wdata_i;
        REG_ORIGIN_Z: ray_q.origin_z     <= cfg_wdata_i;
        REG_DIR_X:    ray_q.dir_x        <= cfg_wdata_i[DIR_W-1:0];
        REG_DIR_Y:    ray_q.dir_y        <= cfg_wdata_i[DIR_W-1:0];
        REG_DIR_Z:    ray_q.dir_z        <= cfg_wdata_i[DIR_W-1:0];
        REG_MAX_DIST: ray_q.max_distance <= cfg_wdata_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  rbnh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_box_i   (in_box_i),
    .in_ready_o (in_ready_o),
    .ray_i      (ray_q),
    .max_wr_i   (max_wr),
    .max_val_i  (cfg_wdata_i[DIST_W-1:0]),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== hw/rtl/rbnh_checker.sv =====
// ---------------------------------------------------------------------------
// rbnh_checker: port level checks for the ray/box nearest hit block
// Watches the top level ports only; bound to the top level below.
// ---------------------------------------------------------------------------
module rbnh_checker import rbnh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input res_t out_res_o
);

  // a held result word does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result word changed while stalled");

  // one box in flight: no accept on the cycle after an accept
  a_one_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("box accepted while busy");

  // a new result comes from a finishing box, never from idle
  a_res_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.any_hit |-> out_res_o.hit_box_index == '0)
    else $error("miss with non-zero index");

endmodule

bind ray_box_nearest_hit_top rbnh_checker u_rbnh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

// ===== tb/sv/ray_box_nearest_hit_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_box_nearest_hit_top_tb: self-checking bench for the nearest hit caster
// Streams box queries under several ray settings, predicts each query word
// with an exact fixed-point slab test and compares it field by field.
// ---------------------------------------------------------------------------
module ray_box_nearest_hit_top_tb;
  import rbnh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int                   IDLE_WAIT  = 400;
  localparam int                   WDOG_LIMIT = 20000;

  class hit_scoreboard;
    logic signed [COORD_W-1:0] org[3];
    logic signed [DIR_W-1:0]   dirv[3];
    logic [DIST_W-1:0]         max_d;
    longint                    nearest;
    int                        near_idx;
    int                        box_cnt;
    bit                        found;
    res_t                      pending[$];
    int                        errors;

    function new();
      org = '{0, 0, 0};
      dirv = '{DIR_X_RST, 0, 0};
      max_d = MAX_DIST_RST;
      errors = 0;
      new_query();
    endfunction

    function void new_query();
      nearest = max_d;
      near_idx = 0;
      box_cnt = 0;
      found = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ORIGIN_X: org[0] = v;
        REG_ORIGIN_Y: org[1] = v;
        REG_ORIGIN_Z: org[2] = v;
        REG_DIR_X:    dirv[0] = v[DIR_W-1:0];
        REG_DIR_Y:    dirv[1] = v[DIR_W-1:0];
        REG_DIR_Z:    dirv[2] = v[DIR_W-1:0];
        REG_MAX_DIST: begin
          max_d = v[DIST_W-1:0];
          if (box_cnt == 0 && !found) nearest = max_d;
        end
        default: ;
      endcase
    endfunction

    function void note_box(box_t b);
      longint lo[3], hi[3], o, d, t0, t1, tmin, tmax, x;
      bit     hit;
      lo[0] = $signed(b.box_lo_x); lo[1] = $signed(b.box_lo_y);
      lo[2] = $signed(b.box_lo_z);
      hi[0] = $signed(b.box_hi_x); hi[1] = $signed(b.box_hi_y);
      hi[2] = $signed(b.box_hi_z);
      tmin = 0;
      tmax = nearest;
      hit = 1;
      for (int a = 0; a < 3 && hit; a++) begin
        o = $signed(org[a]);
        d = $signed(dirv[a]);
        if (d == 0) begin
          if (o < lo[a] || o > hi[a]) hit = 0;
        end else begin
          t0 = ((lo[a] - o) * 65536) / d;
          t1 = ((hi[a] - o) * 65536) / d;
          if (t0 > t1) begin
            x = t0; t0 = t1; t1 = x;
          end
          if (t0 > tmin) tmin = t0;
          if (t1 < tmax) tmax = t1;
          if (tmin > tmax) hit = 0;
        end
      end
      // equal distance keeps the earlier box
      if (hit && tmin < nearest) begin
        nearest = tmin;
        near_idx = box_cnt;
        found = 1;
      end
      if (box_cnt < MAX_BOXES - 1) box_cnt++;
      if (b.last_box) begin
        pending.push_back({found, nearest[DIST_W-1:0], near_idx[HIT_IDX_W-1:0]});
        new_query();
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(res_t r);
      res_t e;
      if (pending.size() == 0) begin
        report("unexpected word", r, 0);
        return;
      end
      e = pending.pop_front();
      if (r.any_hit !== e.any_hit) report("any_hit", r.any_hit, e.any_hit);
      if (r.hit_distance !== e.hit_distance)
        report("hit_distance", r.hit_distance, e.hit_distance);
      if (r.hit_box_index !== e.hit_box_index)
        report("hit_box_index", r.hit_box_index, e.hit_box_index);
    endtask
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  in_valid_i = 0;
  logic                  in_ready_o;
  box_t                  in_box_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 0;
  res_t                  out_res_o;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  hit_scoreboard sb = new();
  bit            quiet = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;

  ray_box_nearest_hit_top u_dut (.*);

  always #4 clk_i = ~clk_i;

  // receiver with bursty stalls
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check(out_res_o);
    if (!quiet && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic box_t mk_box(longint lx, longint ly, longint lz,
                                  longint hx, longint hy, longint hz, bit last);
    box_t b;
    b.box_lo_x = COORD_W'(lx); b.box_lo_y = COORD_W'(ly); b.box_lo_z = COORD_W'(lz);
    b.box_hi_x = COORD_W'(hx); b.box_hi_y = COORD_W'(hy); b.box_hi_z = COORD_W'(hz);
    b.last_box = last;
    return b;
  endfunction

  task automatic send_box(box_t b);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_box_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_box(b);
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, logic [17:0] dx, dy, dz,
                         logic [30:0] md);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_ORIGIN_Z, oz);
    cfg_write(REG_DIR_X, {14'(0), dx});
    cfg_write(REG_DIR_Y, {14'(0), dy});
    cfg_write(REG_DIR_Z, {14'(0), dz});
    cfg_write(REG_UNUSED, $urandom);
    cfg_write(REG_MAX_DIST, {1'b0, md});
    cfg_we_i <= 0;
  endtask

  function automatic logic [17:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'd0;
      3: return 18'h20000;   // out of range, most negative
      4: return 18'h1FFFF;   // out of range positive
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  // box placed on or near the ray path, sometimes noise or inverted
  function automatic box_t rand_box(bit last);
    longint c[3], lo[3], hi[3], t, x;
    int     kind;
    kind = $urandom_range(0, 19);
    if (kind < 3)
      return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
    t = $urandom_range(0, 250);
    for (int a = 0; a < 3; a++) begin
      c[a] = longint'($signed(sb.org[a])) + (longint'($signed(sb.dirv[a])) * t)
             + $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      lo[a] = c[a] - $urandom_range(0, 6 << 16);
      hi[a] = c[a] + $urandom_range(0, 6 << 16);
      if (kind == 3 && a == $urandom_range(0, 2)) begin
        x = lo[a]; lo[a] = hi[a]; hi[a] = x;
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], last);
  endfunction

  task automatic run_queries(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_box(rand_box(i == len - 1));
      sent += len;
    end
    wait_idle();
  endtask

  localparam longint M = 65536;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset ray: +x from origin, range 200
    send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    send_box(mk_box(50*M, -M, -M, 60*M, M, M, 0));
    send_box(mk_box(20*M, -M, -M, 10*M, M, M, 0));     // inverted on moving axis
    send_box(mk_box(10*M, M, -M, 20*M, 2*M, M, 0));    // parallel axis misses
    send_box(mk_box(10*M, -M, M, 20*M, M, -M, 0));     // inverted on parallel axis
    send_box(mk_box(10*M, -M, -M, 20*M, M, M, 0));     // equal distance next
    send_box(mk_box(10*M, -M, -M, 30*M, M, M, 1));
    send_box(mk_box(-30*M, -M, -M, -10*M, M, M, 0));   // behind origin
    send_box(mk_box(300*M, -M, -M, 400*M, M, M, 0));   // past range
    send_box(mk_box(-M, -M, -M, M, M, M, 1));          // origin inside
    send_box(mk_box(200*M, 0, 0, 210*M, 0, 0, 1));     // touches range end
    wait_idle();

    set_ray(0, 0, 0, 18'h20000, 18'h1FFFF, -18'sd65536, 31'h7FFF_FFFF);
    send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    send_box(mk_box(-40*M, 10*M, -30*M, -10*M, 40*M, -5*M, 1));
    wait_idle();
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 18'sd65536, 18'sd65536, 0, 0);
    send_box(mk_box(32'h7FFF_FFFF, 32'h8000_0000, -M, 32'h7FFF_FFFF, 0, M, 1));
    send_box(mk_box(0, 0, -M, M, M, M, 1));
    wait_idle();

    // long query of parallel misses, then a hit around the origin
    set_ray(0, 0, 0, 0, 0, 0, 31'd1000);
    for (int i = 0; i < 40; i++) send_box(mk_box(M, M, M, 2*M, 2*M, 2*M, 0));
    send_box(mk_box(-M, -M, -M, M, M, M, 1));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) quiet = 1;
      set_ray(pick_origin(), pick_origin(), pick_origin(), pick_dir(), pick_dir(),
              pick_dir(), ($urandom_range(0, 5) == 0) ? 31'h7FFF_FFFF
                          : 31'($urandom_range(0, 300) * M));
      run_queries(95);
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
